// ===== hdl/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin slice scheduler package
// Shared types, codes and constants for the scheduler cells and top level.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // Default table depth and fixed field widths.
  localparam int unsigned MaxJobsDef = 16;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned JobNumW    = 5;
  localparam int unsigned ElapsedW   = 21;
  localparam int unsigned ElapsedOutW = 20;

  // Slice length after reset.
  localparam logic [TimeW-1:0] QuantumRst = TimeW'(2);

  // Command codes.
  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpSlice = 2'd1,
    OpClear = 2'd2
  } op_e;

  // Error codes.
  typedef enum logic [1:0] {
    ErrOk         = 2'd0,
    ErrFull       = 2'd1,
    ErrOddQuantum = 2'd2
  } err_e;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StScan,
    StResp
  } state_e;

  // Command beat.
  typedef struct packed {
    logic [1:0]       opcode;
    logic [TimeW-1:0] arrival_time;
    logic [TimeW-1:0] burst_time;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic [JobNumW-1:0]     job_number;
    logic [TimeW-1:0]       slice_length;
    logic [ElapsedOutW-1:0] elapsed_time;
    logic                   all_done;
    logic [1:0]             error_code;
  } res_t;

  // Controls broadcast from the controller to every cell.
  typedef struct packed {
    logic insert;      // place the new job into the sorted row
    logic clear;       // empty the table
    logic seed;        // plant the scan token at the cursor
    logic restart;     // cursor is not on a valid entry, start at the head
    logic scan;        // token walks one cell
    logic grant_seen;  // some cell granted a slice this cycle
  } cell_ctl_t;

  // Token and grant handed from one cell to its neighbour.
  typedef struct packed {
    logic tok;
    logic grant;
  } link_t;

endpackage

// ===== hdl/rrs_cell.sv =====
// ----------------------------------------------------------------------------
// Scheduler cell
// Holds one table entry, takes part in sorted insertion and passes the
// round-robin scan token and cursor on to its neighbour.
// ----------------------------------------------------------------------------
module rrs_cell #(
  parameter bit          IsHome = 1'b0,
  parameter int unsigned NumW   = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrs_pkg::cell_ctl_t          ctl_i,
  input  logic [rrs_pkg::TimeW-1:0]   new_arr_i,
  input  logic [rrs_pkg::TimeW-1:0]   new_burst_i,
  input  logic [NumW-1:0]             new_num_i,
  input  logic [rrs_pkg::TimeW-1:0]   quantum_i,
  input  logic [rrs_pkg::TimeW-1:0]   prev_arr_i,
  input  logic [rrs_pkg::TimeW-1:0]   prev_rem_i,
  input  logic [NumW-1:0]             prev_num_i,
  input  logic                        prev_valid_i,
  input  logic                        prev_ins_i,
  input  rrs_pkg::link_t              link_i,
  input  logic                        next_valid_i,
  output logic [rrs_pkg::TimeW-1:0]   arr_o,
  output logic [rrs_pkg::TimeW-1:0]   rem_o,
  output logic [NumW-1:0]             num_o,
  output logic                        valid_o,
  output logic                        ins_o,
  output rrs_pkg::link_t              link_o,
  output rrs_pkg::link_t              wrap_o,
  output logic                        curv_o,
  output logic                        work_o,
  output logic                        grant_o,
  output logic [rrs_pkg::TimeW-1:0]   slice_o,
  output logic [NumW-1:0]             gnum_o
);

  logic [rrs_pkg::TimeW-1:0] arr_q, arr_d;
  logic [rrs_pkg::TimeW-1:0] rem_q, rem_d;
  logic [NumW-1:0]           num_q, num_d;
  logic                      valid_q, valid_d;
  logic                      cur_q, cur_d;
  logic                      tok_q, tok_d;
  logic                      last;
  logic                      grant;
  logic [rrs_pkg::TimeW-1:0] slice;

  // The new job goes in front of this entry when the entry is empty or arrives
  // strictly later, which keeps equal arrivals in load order.
  assign ins_o = !valid_q || (arr_q > new_arr_i);

  // This entry is the last occupied one of the table.
  assign last = valid_q && !next_valid_i;

  // Grant when the token sits here and work remains.
  assign grant = ctl_i.scan && tok_q && (rem_q != '0);
  assign slice = (rem_q < quantum_i) ? rem_q : quantum_i;

  assign link_o.tok   = tok_q && !last;
  assign link_o.grant = grant && !last;
  assign wrap_o.tok   = tok_q && last;
  assign wrap_o.grant = grant && last;

  assign arr_o   = arr_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign valid_o = valid_q;
  assign curv_o  = cur_q && valid_q;
  assign work_o  = valid_q && (rem_q != '0);
  assign grant_o = grant;
  assign slice_o = grant ? slice : '0;
  assign gnum_o  = grant ? num_q : '0;

  // Next entry contents and control bits.
  always_comb begin
    arr_d   = arr_q;
    rem_d   = rem_q;
    num_d   = num_q;
    valid_d = valid_q;
    cur_d   = cur_q;
    tok_d   = tok_q;
    priority if (ctl_i.clear) begin
      valid_d = 1'b0;
      cur_d   = IsHome;
      tok_d   = 1'b0;
    end else if (ctl_i.insert) begin
      if (prev_ins_i) begin
        arr_d   = prev_arr_i;
        rem_d   = prev_rem_i;
        num_d   = prev_num_i;
        valid_d = prev_valid_i;
      end else if (ins_o) begin
        arr_d   = new_arr_i;
        rem_d   = new_burst_i;
        num_d   = new_num_i;
        valid_d = 1'b1;
      end
    end else if (ctl_i.seed) begin
      tok_d = curv_o || (IsHome && ctl_i.restart);
    end else if (ctl_i.scan) begin
      tok_d = link_i.tok;
      if (ctl_i.grant_seen) begin
        cur_d = link_i.grant;
      end
      if (grant) begin
        rem_d = rem_q - slice;
      end
    end
  end

  // Control bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cur_q   <= IsHome;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      cur_q   <= cur_d;
      tok_q   <= tok_d;
    end
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    arr_q <= arr_d;
    rem_q <= rem_d;
    num_q <= num_d;
  end

endmodule

// ===== hdl/round_robin_slice_scheduler.sv =====
// A slice request with an even quantum on a non-empty table walks the scan
// token along the row of cells, stepping one cell per cycle, until a cell grants
// or the token has passed every job, then shows its result beat; every other
// request goes from the execute state straight to the response state. A new
// command is taken only once the block is idle after its result beat. Results are strobed for one cycle.
// Reset empties the table, zeroes the elapsed time and sets the quantum to 2.
// ----------------------------------------------------------------------------
// Round-robin slice scheduler
// Sorted job table built from a row of cells, with a circular token scan that
// grants time slices of at most one quantum to jobs with work left.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler #(
  parameter int unsigned MAX_JOBS = rrs_pkg::MaxJobsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  rrs_pkg::cmd_t             cmd_i,
  output logic                      done_o,
  output rrs_pkg::res_t             res_o,
  input  logic                      cfg_we_i,
  input  logic [rrs_pkg::TimeW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_JOBS + 1);

  rrs_pkg::state_e            state_q, state_d;
  rrs_pkg::cmd_t              cmd_q;
  logic [rrs_pkg::TimeW-1:0]  quantum_q;
  logic [CntW-1:0]            count_q;
  logic [CntW-1:0]            step_q;
  logic [rrs_pkg::ElapsedW-1:0] elapsed_q;
  logic [CntW-1:0]            job_q;
  logic [rrs_pkg::TimeW-1:0]  slice_q;
  logic [1:0]                 err_q;

  rrs_pkg::cell_ctl_t         ctl;
  logic                       is_full;
  logic                       odd_quantum;
  logic [CntW-1:0]            new_num;
  logic [rrs_pkg::ElapsedW:0] elapsed_sum;

  // Neighbour wiring of the cell row.
  logic [rrs_pkg::TimeW-1:0]  c_arr   [MAX_JOBS];
  logic [rrs_pkg::TimeW-1:0]  c_rem   [MAX_JOBS];
  logic [CntW-1:0]            c_num   [MAX_JOBS];
  logic [MAX_JOBS-1:0]        c_valid;
  logic [MAX_JOBS-1:0]        c_ins;
  rrs_pkg::link_t             c_link  [MAX_JOBS];
  rrs_pkg::link_t             c_wrap  [MAX_JOBS];
  logic [MAX_JOBS-1:0]        c_curv;
  logic [MAX_JOBS-1:0]        c_work;
  logic [MAX_JOBS-1:0]        c_grant;
  logic [rrs_pkg::TimeW-1:0]  c_slice [MAX_JOBS];
  logic [CntW-1:0]            c_gnum  [MAX_JOBS];

  rrs_pkg::link_t             wrap;
  logic                       any_grant;
  logic [rrs_pkg::TimeW-1:0]  grant_slice;
  logic [CntW-1:0]            grant_num;

  assign is_full     = (count_q == CntW'(MAX_JOBS));
  assign odd_quantum = quantum_q[0];
  assign new_num     = count_q + CntW'(1);

  // Row of cells.
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    rrs_pkg::link_t link_in;
    logic [rrs_pkg::TimeW-1:0] p_arr, p_rem;
    logic [CntW-1:0]           p_num;
    logic                      p_valid, p_ins, n_valid;

    if (i == 0) begin : g_head
      assign link_in = wrap;
      assign p_arr   = '0;
      assign p_rem   = '0;
      assign p_num   = '0;
      assign p_valid = 1'b0;
      assign p_ins   = 1'b0;
    end else begin : g_body
      assign link_in = c_link[i-1];
      assign p_arr   = c_arr[i-1];
      assign p_rem   = c_rem[i-1];
      assign p_num   = c_num[i-1];
      assign p_valid = c_valid[i-1];
      assign p_ins   = c_ins[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_tail
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_valid = c_valid[i+1];
    end

    rrs_cell #(
      .IsHome (i == 0),
      .NumW   (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_arr_i    (cmd_q.arrival_time),
      .new_burst_i  (cmd_q.burst_time),
      .new_num_i    (new_num),
      .quantum_i    (quantum_q),
      .prev_arr_i   (p_arr),
      .prev_rem_i   (p_rem),
      .prev_num_i   (p_num),
      .prev_valid_i (p_valid),
      .prev_ins_i   (p_ins),
      .link_i       (link_in),
      .next_valid_i (n_valid),
      .arr_o        (c_arr[i]),
      .rem_o        (c_rem[i]),
      .num_o        (c_num[i]),
      .valid_o      (c_valid[i]),
      .ins_o        (c_ins[i]),
      .link_o       (c_link[i]),
      .wrap_o       (c_wrap[i]),
      .curv_o       (c_curv[i]),
      .work_o       (c_work[i]),
      .grant_o      (c_grant[i]),
      .slice_o      (c_slice[i]),
      .gnum_o       (c_gnum[i])
    );
  end

  // Collect the wrap-around link and the single granting cell's reply.
  always_comb begin
    wrap        = '0;
    grant_slice = '0;
    grant_num   = '0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      wrap.tok    = wrap.tok | c_wrap[i].tok;
      wrap.grant  = wrap.grant | c_wrap[i].grant;
      grant_slice = grant_slice | c_slice[i];
      grant_num   = grant_num | c_gnum[i];
    end
  end
  assign any_grant = |c_grant;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrs_pkg::StIdle: begin
        if (start) begin
          state_d = rrs_pkg::StExec;
        end
      end
      rrs_pkg::StExec: begin
        if ((cmd_q.opcode == rrs_pkg::OpSlice) && !odd_quantum && (count_q != '0)) begin
          state_d = rrs_pkg::StScan;
        end else begin
          state_d = rrs_pkg::StResp;
        end
      end
      rrs_pkg::StScan: begin
        if (any_grant || (step_q + CntW'(1) == count_q)) begin
          state_d = rrs_pkg::StResp;
        end
      end
      rrs_pkg::StResp: begin
        state_d = rrs_pkg::StIdle;
      end
      default: state_d = rrs_pkg::StIdle;
    endcase
  end

  // Controller outputs.
  always_comb begin
    ctl     = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      rrs_pkg::StIdle: begin
        busy = 1'b0;
      end
      rrs_pkg::StExec: begin
        ctl.insert  = (cmd_q.opcode == rrs_pkg::OpLoad) && !is_full;
        ctl.clear   = (cmd_q.opcode == rrs_pkg::OpClear);
        ctl.seed    = (cmd_q.opcode == rrs_pkg::OpSlice);
        ctl.restart = !(|c_curv);
      end
      rrs_pkg::StScan: begin
        ctl.scan       = 1'b1;
        ctl.grant_seen = any_grant;
      end
      rrs_pkg::StResp: begin
        done_o = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // State register and quantum register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rrs_pkg::StIdle;
      quantum_q <= rrs_pkg::QuantumRst;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
    end
  end

  assign elapsed_sum = {1'b0, elapsed_q} + (rrs_pkg::ElapsedW + 1)'(grant_slice);

  // Table bookkeeping and result fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      elapsed_q <= '0;
      step_q    <= '0;
    end else begin
      unique case (state_q)
        rrs_pkg::StExec: begin
          step_q <= '0;
          if ((cmd_q.opcode == rrs_pkg::OpLoad) && !is_full) begin
            count_q <= new_num;
          end else if (cmd_q.opcode == rrs_pkg::OpClear) begin
            count_q   <= '0;
            elapsed_q <= '0;
          end
        end
        rrs_pkg::StScan: begin
          step_q <= step_q + CntW'(1);
          if (any_grant) begin
            elapsed_q <= elapsed_sum[rrs_pkg::ElapsedW] ? '1
                                                        : elapsed_sum[rrs_pkg::ElapsedW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Command beat and result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == rrs_pkg::StIdle && start) begin
      cmd_q <= cmd_i;
    end
    if (state_q == rrs_pkg::StExec) begin
      slice_q <= '0;
      unique case (cmd_q.opcode)
        rrs_pkg::OpLoad: begin
          job_q <= is_full ? '0 : new_num;
          err_q <= is_full ? rrs_pkg::ErrFull : rrs_pkg::ErrOk;
        end
        rrs_pkg::OpSlice: begin
          job_q <= '0;
          err_q <= odd_quantum ? rrs_pkg::ErrOddQuantum : rrs_pkg::ErrOk;
        end
        default: begin
          job_q <= '0;
          err_q <= rrs_pkg::ErrOk;
        end
      endcase
    end
    if (state_q == rrs_pkg::StScan && any_grant) begin
      job_q   <= grant_num;
      slice_q <= grant_slice;
    end
  end

  // Result beat.
  assign res_o.job_number   = rrs_pkg::JobNumW'(job_q);
  assign res_o.slice_length = slice_q;
  assign res_o.elapsed_time = elapsed_q[rrs_pkg::ElapsedW-1] ? '1
                                                             : elapsed_q[rrs_pkg::ElapsedOutW-1:0];
  assign res_o.all_done     = !(|c_work);
  assign res_o.error_code   = err_q;

endmodule

// ===== hdl/rrs_checker.sv =====
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the command and result ports of the scheduler over time.
// ----------------------------------------------------------------------------
module rrs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input rrs_pkg::res_t res_o
);

  // A taken command makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command taken but block not busy");

  // A result beat only appears while a command is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result beat while idle");

  // The block is free again straight after its result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o))
    else $error("block still busy after result beat");

  // A rejected request grants nothing and names no job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.error_code == rrs_pkg::ErrOddQuantum) |->
      (res_o.slice_length == '0 && res_o.job_number == '0))
    else $error("odd quantum request granted a slice");

  // A non-empty slice always belongs to a job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.slice_length != '0) |-> (res_o.job_number != '0))
    else $error("slice granted without a job number");

endmodule

bind round_robin_slice_scheduler rrs_checker u_rrs_checker (.*);

// ===== dv/rrs_slice_checker.sv =====
// ----------------------------------------------------------------------------
// Round-robin slice scheduler result checker
// Watches the command, configuration and result channels of the scheduler,
// keeps its own copy of the job table, works out the result beat that each
// accepted command must produce and compares it field by field with the beat
// that the block strobes out.
// ----------------------------------------------------------------------------
module rrs_slice_checker
  import rrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  cmd_t              cmd_i,
  input  logic              done_i,
  input  res_t              res_i,
  input  logic              cfg_we_i,
  input  logic [TimeW-1:0]  cfg_wdata_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ElapsedStateMax = (1 << ElapsedW) - 1;
  localparam int unsigned ElapsedOutMax   = (1 << ElapsedOutW) - 1;

  // Predicted scheduler state: the sorted job table and its bookkeeping.
  logic [TimeW-1:0]   arr_tab  [MaxJobsDef];
  logic [TimeW-1:0]   left_tab [MaxJobsDef];
  logic [JobNumW-1:0] num_tab  [MaxJobsDef];
  int unsigned        job_cnt;
  int unsigned        cursor;
  int unsigned        elapsed;
  logic [TimeW-1:0]   quantum;

  // Result beats still owed by the block, oldest first.
  res_t        owed_res_q[$];
  int unsigned fails;
  int unsigned checked;

  // Applies one command to the predicted table and returns the beat it owes.
  task automatic schedule_cmd(input cmd_t c, output res_t r);
    int unsigned pos, first, p, k, i, grant, job;
    logic        idle_all;
    err_e        err;
    job   = 0;
    grant = 0;
    err   = ErrOk;
    case (c.opcode)
      OpLoad: begin
        if (job_cnt >= MaxJobsDef) begin
          err = ErrFull;
        end else begin
          // Later arrivals go behind equal ones, so ties keep load order.
          pos = 0;
          while (pos < job_cnt && arr_tab[pos] <= c.arrival_time) pos++;
          for (i = job_cnt; i > pos; i--) begin
            arr_tab[i]  = arr_tab[i-1];
            left_tab[i] = left_tab[i-1];
            num_tab[i]  = num_tab[i-1];
          end
          job_cnt++;
          arr_tab[pos]  = c.arrival_time;
          left_tab[pos] = c.burst_time;
          num_tab[pos]  = JobNumW'(job_cnt);
          job = job_cnt;
        end
      end
      OpSlice: begin
        if (quantum[0]) begin
          err = ErrOddQuantum;
        end else if (job_cnt != 0) begin
          // Circular search from the cursor for the next job with work left.
          first = (cursor < job_cnt) ? cursor : 0;
          for (k = 0; k < job_cnt; k++) begin
            p = first + k;
            if (p >= job_cnt) p -= job_cnt;
            if (left_tab[p] != 0) begin
              grant = (left_tab[p] < quantum) ? left_tab[p] : quantum;
              left_tab[p] = left_tab[p] - TimeW'(grant);
              elapsed += grant;
              if (elapsed > ElapsedStateMax) elapsed = ElapsedStateMax;
              job    = num_tab[p];
              cursor = (p + 1 >= job_cnt) ? 0 : p + 1;
              break;
            end
          end
        end
      end
      OpClear: begin
        job_cnt = 0;
        cursor  = 0;
        elapsed = 0;
      end
      default: begin
        // The spare code leaves everything as it is.
      end
    endcase
    idle_all = 1'b1;
    for (i = 0; i < job_cnt; i++) begin
      if (left_tab[i] != 0) idle_all = 1'b0;
    end
    r.job_number   = JobNumW'(job);
    r.slice_length = TimeW'(grant);
    r.elapsed_time = ElapsedOutW'((elapsed > ElapsedOutMax) ? ElapsedOutMax : elapsed);
    r.all_done     = idle_all;
    r.error_code   = err;
  endtask

  // Reports one field that differs from its prediction.
  function automatic int unsigned field_diff(string name, logic [31:0] want,
                                             logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Tracks every beat on the three channels at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t        want;
    int unsigned bad;
    if (!rst_ni) begin
      job_cnt  = 0;
      cursor   = 0;
      elapsed  = 0;
      quantum  = QuantumRst;
      owed_res_q.delete();
      fails    = 0;
      checked  = 0;
    end else begin
      if (cfg_we_i) quantum = cfg_wdata_i;
      // Compare a strobed result with the oldest owed beat.
      if (done_i) begin
        if (owed_res_q.size() == 0) begin
          $display("%0t: result beat with nothing owed: got %h", $time, res_i);
          fails++;
        end else begin
          want = owed_res_q.pop_front();
          bad  = field_diff("job_number", want.job_number, res_i.job_number)
               + field_diff("slice_length", want.slice_length, res_i.slice_length)
               + field_diff("elapsed_time", want.elapsed_time, res_i.elapsed_time)
               + field_diff("all_done", want.all_done, res_i.all_done)
               + field_diff("error_code", want.error_code, res_i.error_code);
          if (bad != 0) fails++;
          checked++;
        end
      end
      // A command is taken when start is high and the block is not busy.
      if (start_i && !busy_i) begin
        schedule_cmd(cmd_i, want);
        owed_res_q.push_back(want);
      end
    end
    fail_count_o <= fails;
    pending_o    <= owed_res_q.size();
    checked_o    <= checked;
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Round-robin slice scheduler testbench
// Drives a short directed list of commands through the scheduler, then random
// episodes of table loads and slice requests under varied quantum settings and
// sender idling, while the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrs_pkg::*;

  // The command code that the block leaves unused.
  localparam logic [1:0]  OpSpare    = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBeats = 130;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             start       = 1'b0;
  cmd_t             cmd         = '0;
  logic             cfg_we      = 1'b0;
  logic [TimeW-1:0] cfg_wdata   = '0;
  logic             busy;
  logic             done;
  res_t             res;

  int unsigned fail_count, pending, checked;
  int unsigned cycles    = 0;
  int unsigned idle_pct  = 0;
  int unsigned sent      = 0;
  int unsigned n_load    = 0;
  int unsigned n_slice   = 0;
  int unsigned n_clear   = 0;
  int unsigned n_spare   = 0;
  int unsigned n_quantum = 0;

  always #1 clk = ~clk;

  round_robin_slice_scheduler #(
    .MAX_JOBS (MaxJobsDef)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd),
    .done_o      (done),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  rrs_slice_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .done_i       (done),
    .res_i        (res),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d beats outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sends one command beat after a random gap and holds it until taken.
  task automatic send_cmd(input logic [1:0] op, input logic [TimeW-1:0] arr,
                          input logic [TimeW-1:0] burst);
    @(posedge clk);
    while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    cmd   <= '{opcode: op, arrival_time: arr, burst_time: burst};
    do @(posedge clk); while (busy);
    start <= 1'b0;
    case (op)
      OpLoad:  n_load++;
      OpSlice: n_slice++;
      OpClear: n_clear++;
      default: n_spare++;
    endcase
    if (op != OpSpare) sent++;
  endtask

  // Writes the quantum once the block has delivered everything owed.
  task automatic set_quantum(input logic [TimeW-1:0] q);
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_quantum++;
  endtask

  // Arrival times cluster low so that ties are common.
  function automatic logic [TimeW-1:0] rand_arrival();
    return ($urandom_range(0, 9) < 6) ? TimeW'($urandom_range(0, 7))
                                      : TimeW'($urandom_range(0, 65535));
  endfunction

  // Bursts are mostly short so that jobs run to completion.
  function automatic logic [TimeW-1:0] rand_burst();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 8)  return TimeW'($urandom_range(1, 24));
    return TimeW'($urandom_range(0, 65535));
  endfunction

  // Quantum choice for one episode, extremes and odd values included.
  function automatic logic [TimeW-1:0] rand_quantum();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return TimeW'(2 * $urandom_range(1, 8));
    if (r < 60) return TimeW'(2);
    if (r < 70) return TimeW'(65534);
    if (r < 78) return '0;
    if (r < 88) return TimeW'($urandom_range(0, 65535)) | TimeW'(1);
    return TimeW'($urandom_range(0, 65535));
  endfunction

  // One episode: an optional clear, a batch of loads, then mostly slices.
  task automatic run_episode();
    int unsigned jobs, turns, r;
    set_quantum(rand_quantum());
    if ($urandom_range(0, 3) != 0) send_cmd(OpClear, TimeW'($urandom), TimeW'($urandom));
    jobs = $urandom_range(1, 18);
    repeat (jobs) send_cmd(OpLoad, rand_arrival(), rand_burst());
    turns = $urandom_range(jobs, 4 * jobs);
    repeat (turns) begin
      r = $urandom_range(0, 99);
      if (r < 8)       send_cmd(OpLoad, rand_arrival(), rand_burst());
      else if (r < 11) send_cmd(OpSpare, TimeW'($urandom), TimeW'($urandom));
      else if (r < 13) send_cmd(OpClear, TimeW'($urandom), TimeW'($urandom));
      else             send_cmd(OpSlice, TimeW'($urandom), TimeW'($urandom));
    end
  endtask

  initial begin
    int unsigned goal;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, zero bursts, ties at both ends of the range.
    send_cmd(OpSpare, 16'hFFFF, 16'hFFFF);
    send_cmd(OpSlice, '0, '0);
    send_cmd(OpLoad, 16'h0000, 16'h0000);
    send_cmd(OpLoad, 16'hFFFF, 16'hFFFF);
    send_cmd(OpLoad, 16'h0000, 16'd7);
    send_cmd(OpLoad, 16'hFFFF, 16'd1);
    repeat (3) send_cmd(OpSlice, '0, '0);
    // A load while serving leaves the cursor where it is.
    send_cmd(OpLoad, 16'd1, 16'd2);
    send_cmd(OpSlice, '0, '0);
    // Odd, zero and largest even quantum.
    set_quantum(16'hFFFF);
    send_cmd(OpSlice, '0, '0);
    set_quantum(16'h0000);
    send_cmd(OpSlice, '0, '0);
    set_quantum(16'hFFFE);
    repeat (2) send_cmd(OpSlice, '0, '0);
    // Fill the table, then one load too many.
    repeat (12) send_cmd(OpLoad, TimeW'($urandom), TimeW'($urandom));
    send_cmd(OpClear, '0, '0);
    send_cmd(OpSlice, '0, '0);

    // Random episodes: sender idles rarely, then often, then never.
    idle_pct = 24;
    goal = sent + PhaseBeats;
    while (sent < goal) run_episode();
    idle_pct = 76;
    goal = sent + PhaseBeats;
    while (sent < goal) run_episode();
    idle_pct = 0;
    goal = sent + PhaseBeats;
    while (sent < goal) run_episode();

    // Drain, then allow for a stray late beat.
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("Covered %0d loads, %0d slice requests, %0d clears, %0d unused codes",
             n_load, n_slice, n_clear, n_spare);
    $display("over %0d quantum settings; %0d result beats compared", n_quantum, checked);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
